[rtl/nonrestoring_unsigned_divider_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the nonrestoring unsigned divider
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NONRESTORING_UNSIGNED_DIVIDER_MACROS_SVH
`define NONRESTORING_UNSIGNED_DIVIDER_MACROS_SVH

// Same-cycle implication.
`define NRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nrd_pkg.sv]
// ----------------------------------------------------------------------------
// Divider package
// Control types shared by the pipeline stages of the divider.
// ----------------------------------------------------------------------------
package nrd_pkg;

  // Control that travels with each request through the pipeline.
  typedef struct packed {
    logic valid;  // stage holds a request
    logic dbz;    // the divisor of this request is zero
  } stage_ctl_t;

endpackage

[rtl/nrd_stage.sv]
// ----------------------------------------------------------------------------
// Divider round stage
// One nonrestoring round: shift, add or subtract the divisor, then register.
// ----------------------------------------------------------------------------
module nrd_stage #(
  parameter int WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nrd_pkg::stage_ctl_t up_ctl,
  input  logic [WIDTH:0]     up_a,
  input  logic [WIDTH-1:0]   up_q,
  input  logic [WIDTH-1:0]   up_d,
  output logic               up_ready,
  output nrd_pkg::stage_ctl_t dn_ctl,
  output logic [WIDTH:0]     dn_a,
  output logic [WIDTH-1:0]   dn_q,
  output logic [WIDTH-1:0]   dn_d,
  input  logic               dn_ready
);

  nrd_pkg::stage_ctl_t ctl_r;
  logic [WIDTH:0]      a_r, a_nxt, a_sh, d_ext;
  logic [WIDTH-1:0]    q_r, q_nxt, d_r;

  // The sign is taken before the shift and picks add or subtract.
  always_comb begin
    a_sh  = {up_a[WIDTH-1:0], up_q[WIDTH-1]};
    d_ext = {1'b0, up_d};
    a_nxt = up_a[WIDTH] ? (a_sh + d_ext) : (a_sh - d_ext);
    q_nxt = {up_q[WIDTH-2:0], ~a_nxt[WIDTH]};
  end

  assign up_ready = !ctl_r.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_ready) begin
      ctl_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      a_r <= a_nxt;
      q_r <= q_nxt;
      d_r <= up_d;
    end
  end

  assign dn_ctl = ctl_r;
  assign dn_a   = a_r;
  assign dn_q   = q_r;
  assign dn_d   = d_r;

endmodule

[rtl/nrd_fix.sv]
// ----------------------------------------------------------------------------
// Divider correction stage
// Adds the divisor back to a negative remainder and holds the result.
// ----------------------------------------------------------------------------
module nrd_fix #(
  parameter int WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nrd_pkg::stage_ctl_t up_ctl,
  input  logic [WIDTH:0]     up_a,
  input  logic [WIDTH-1:0]   up_q,
  input  logic [WIDTH-1:0]   up_d,
  output logic               up_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WIDTH-1:0]   out_quotient,
  output logic [WIDTH-1:0]   out_remainder,
  output logic               out_divide_by_zero
);

  logic             valid_r;
  logic             dbz_r;
  logic [WIDTH-1:0] quo_r, rem_r, rem_nxt;

  assign rem_nxt  = up_a[WIDTH] ? (up_a[WIDTH-1:0] + up_d) : up_a[WIDTH-1:0];
  assign up_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      quo_r <= up_q;
      rem_r <= rem_nxt;
      dbz_r <= up_ctl.dbz;
    end
  end

  assign out_valid          = valid_r;
  assign out_quotient       = quo_r;
  assign out_remainder      = rem_r;
  assign out_divide_by_zero = dbz_r;

endmodule

[rtl/nonrestoring_unsigned_divider.sv]
// ----------------------------------------------------------------------------
// Nonrestoring unsigned divider
// Fully pipelined WIDTH-bit unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
// The divider takes one request per clock cycle while in_stall is low, and
// returns each result from the fix stage in request order. There is
// one pipeline stage per quotient bit, each holding a single WIDTH+1 bit add
// or subtract, followed by one stage that adds the divisor back to a negative
// remainder and drives the output registers; that adder per stage sets the
// clock rate. Each stage has its own valid bit and advances whenever the
// stage after it is empty or moving, so a stall on the result side fills
// empty slots first and only stalls the request side when every stage holds
// a request. A zero divisor needs no special path: the rounds then naturally
// yield an all-ones quotient and the dividend as remainder, and the flag is
// carried along with the request.
// ----------------------------------------------------------------------------
module nonrestoring_unsigned_divider #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] in_dividend,
  input  logic [WIDTH-1:0] in_divisor,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_quotient,
  output logic [WIDTH-1:0] out_remainder,
  output logic             out_divide_by_zero
);

  // Index k holds what enters round stage k; index WIDTH feeds the fix stage.
  nrd_pkg::stage_ctl_t ctl_s [0:WIDTH];
  logic [WIDTH:0]      a_s   [0:WIDTH];
  logic [WIDTH-1:0]    q_s   [0:WIDTH];
  logic [WIDTH-1:0]    d_s   [0:WIDTH];
  logic                rdy_s [0:WIDTH];

  // The partial remainder starts at zero and the quotient register starts
  // at the dividend.
  always_comb begin
    ctl_s[0].valid = in_valid;
    ctl_s[0].dbz   = (in_divisor == '0);
    a_s[0]         = '0;
    q_s[0]         = in_dividend;
    d_s[0]         = in_divisor;
  end

  assign in_stall = !rdy_s[0];

  for (genvar i = 0; i < WIDTH; i++) begin : g_round
    nrd_stage #(.WIDTH(WIDTH)) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_ctl   (ctl_s[i]),
      .up_a     (a_s[i]),
      .up_q     (q_s[i]),
      .up_d     (d_s[i]),
      .up_ready (rdy_s[i]),
      .dn_ctl   (ctl_s[i+1]),
      .dn_a     (a_s[i+1]),
      .dn_q     (q_s[i+1]),
      .dn_d     (d_s[i+1]),
      .dn_ready (rdy_s[i+1])
    );
  end

  nrd_fix #(.WIDTH(WIDTH)) u_fix (
    .clk                (clk),
    .rst_n              (rst_n),
    .up_ctl             (ctl_s[WIDTH]),
    .up_a               (a_s[WIDTH]),
    .up_q               (q_s[WIDTH]),
    .up_d               (d_s[WIDTH]),
    .up_ready           (rdy_s[WIDTH]),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_quotient       (out_quotient),
    .out_remainder      (out_remainder),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

[rtl/nrd_checker.sv]
// ----------------------------------------------------------------------------
// Divider port checker
// Watches the divider ports and flags behavior the pipeline must not show.
// ----------------------------------------------------------------------------
`include "nonrestoring_unsigned_divider_macros.svh"

module nrd_checker #(
  parameter int WIDTH = 16
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [WIDTH-1:0] in_dividend,
  input logic [WIDTH-1:0] in_divisor,
  input logic             out_valid,
  input logic             out_stall,
  input logic [WIDTH-1:0] out_quotient,
  input logic [WIDTH-1:0] out_remainder,
  input logic             out_divide_by_zero
);

  // A stalled result stays put.
  `NRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_quotient) && $stable(out_remainder) && $stable(out_divide_by_zero), "stalled result changed")

  // The request side only backs up when a result is waiting.
  `NRD_ASSERT_NOW(a_stall_full, in_stall, out_valid, "request stalled with empty output")

  // A zero divisor yields an all-ones quotient.
  `NRD_ASSERT_NOW(a_dbz_quo, out_valid && out_divide_by_zero, out_quotient == {WIDTH{1'b1}}, "divide by zero quotient not all ones")

  // On a 0/0 request taken with no result out, a flagged result then has a zero remainder or all-ones quotient.
  `NRD_ASSERT_NEXT(a_dbz_empty, in_valid && !in_stall && in_divisor == '0 && in_dividend == '0 && !out_valid, !out_valid || !out_divide_by_zero || out_remainder == '0 || out_quotient == {WIDTH{1'b1}}, "divide by zero result inconsistent")

endmodule

bind nonrestoring_unsigned_divider nrd_checker #(.WIDTH(WIDTH)) u_nrd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_dividend        (in_dividend),
  .in_divisor         (in_divisor),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_quotient       (out_quotient),
  .out_remainder      (out_remainder),
  .out_divide_by_zero (out_divide_by_zero)
);
